[design/elevator_request_scheduler_assert.svh]
// ---------------------------------------------------------------------------
// Elevator request scheduler assertion macros
// Immediate-style wrappers around concurrent checks; empty for synthesis.
// ---------------------------------------------------------------------------
`ifndef ELEVATOR_REQUEST_SCHEDULER_ASSERT_SVH
`define ELEVATOR_REQUEST_SCHEDULER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define ERS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ERS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ERS_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define ERS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[design/ers_pkg.sv]
// ---------------------------------------------------------------------------
// Elevator request scheduler package
// Shared constants, floor type and controller/datapath command structs.
// ---------------------------------------------------------------------------
`default_nettype none

package ers_pkg;

    // Number of floors served; floors are numbered from one.
    localparam int FLOOR_COUNT = 8;
    // Width of a floor number on the ports.
    localparam int FLOOR_W     = 4;
    // Width of a request bit index.
    localparam int IDX_W       = $clog2(FLOOR_COUNT);

    typedef logic [FLOOR_W-1:0] t_floor;
    typedef logic [IDX_W-1:0]   t_idx;
    typedef logic [2:0]         t_pick;

    localparam t_floor NO_FLOOR     = t_floor'(0);
    localparam t_floor BOTTOM_FLOOR = t_floor'(1);
    localparam t_floor TOP_FLOOR    = t_floor'(FLOOR_COUNT);

    // Item kinds.
    localparam logic KIND_CALL = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // Target selection modes.
    localparam logic MODE_NAIVE = 1'b0;
    localparam logic MODE_SCAN  = 1'b1;

    // Controller to datapath.
    typedef struct packed {
        logic take;   // latch the accepted input word
        logic exec;   // perform the call or tick action
        logic step;   // advance the selection walk one floor
        logic load;   // load the result register
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic need_search;  // tick needs a target selection
        logic hit;          // walk found the target this cycle
    } t_stat;

endpackage

`default_nettype wire

[design/ers_intf.sv]
// ---------------------------------------------------------------------------
// Elevator request scheduler channel interfaces
// Valid/ready channels for input words, result words and configuration.
// ---------------------------------------------------------------------------
`default_nettype none

interface ers_item_if;
    logic             valid;
    logic             ready;
    logic             kind;
    ers_pkg::t_floor  call_floor;
    ers_pkg::t_pick   pick;

    modport source (output valid, output kind, output call_floor, output pick,
                    input ready);
    modport sink   (input valid, input kind, input call_floor, input pick,
                    output ready);
endinterface

interface ers_result_if;
    logic             valid;
    logic             ready;
    logic             call_accepted;
    ers_pkg::t_floor  cab_floor;
    ers_pkg::t_floor  goal_floor;
    logic             door_open;
    logic             heading_up;

    modport source (output valid, output call_accepted, output cab_floor,
                    output goal_floor, output door_open, output heading_up,
                    input ready);
    modport sink   (input valid, input call_accepted, input cab_floor,
                    input goal_floor, input door_open, input heading_up,
                    output ready);
endinterface

interface ers_cfg_if;
    logic valid;
    logic ready;
    logic select_mode;

    modport source (output valid, output select_mode, input ready);
    modport sink   (input valid, input select_mode, output ready);
endinterface

`default_nettype wire

[design/elevator_request_scheduler.sv]
// ---------------------------------------------------------------------------
// Elevator request scheduler
// One request bit per floor; calls set bits, ticks select, move and serve.
// ---------------------------------------------------------------------------
// Each input word yields exactly one result word. A call word (kind 0) is
// latched at the accepting edge, acted on in the next cycle and loaded into
// the result register once that register is free. A tick word that moves
// the cab or serves the target goes the same way. A tick that must select a
// target adds a walk over the floors, one floor per cycle. In scan mode the
// walk spans at most one full round trip. In naive mode it can go round the
// building more than once, because the walk wraps around and counts pick
// down on each pending floor. The walk through the single shared floor
// stepper sets the rate. A new word is taken once the previous one has been
// handed to the result register, even while that result still waits to be
// taken. The configuration channel is always ready; write select_mode only
// while the block is idle.
// ---------------------------------------------------------------------------
`default_nettype none

module elevator_request_scheduler (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    ers_item_if.sink    i_item,
    ers_result_if.source o_result,
    ers_cfg_if.sink     i_cfg
);

    ers_pkg::t_cmd  cmd;
    ers_pkg::t_stat stat;
    logic           in_ready;
    logic           out_valid;

    // Sequence each word through the controller.
    ers_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_result.ready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    // Hold all floor state and the result register in the datapath.
    ers_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_kind          (i_item.kind),
        .i_call_floor    (i_item.call_floor),
        .i_pick          (i_item.pick),
        .i_cfg_we        (i_cfg.valid),
        .i_cfg_mode      (i_cfg.select_mode),
        .o_call_accepted (o_result.call_accepted),
        .o_cab_floor     (o_result.cab_floor),
        .o_goal_floor    (o_result.goal_floor),
        .o_door_open     (o_result.door_open),
        .o_heading_up    (o_result.heading_up)
    );

    assign i_item.ready   = in_ready;
    assign o_result.valid = out_valid;
    // Configuration writes are taken at once.
    assign i_cfg.ready    = 1'b1;

endmodule

`default_nettype wire

[design/ers_datapath.sv]
// ---------------------------------------------------------------------------
// Elevator request scheduler datapath
// Request bits, cab state, selection walk and result register.
// ---------------------------------------------------------------------------
`default_nettype none

module ers_datapath (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire ers_pkg::t_cmd    i_cmd,
    output      ers_pkg::t_stat   o_stat,
    input  wire logic             i_kind,
    input  wire ers_pkg::t_floor  i_call_floor,
    input  wire ers_pkg::t_pick   i_pick,
    input  wire logic             i_cfg_we,
    input  wire logic             i_cfg_mode,
    output      logic             o_call_accepted,
    output      ers_pkg::t_floor  o_cab_floor,
    output      ers_pkg::t_floor  o_goal_floor,
    output      logic             o_door_open,
    output      logic             o_heading_up
);

`include "elevator_request_scheduler_assert.svh"

    logic [ers_pkg::FLOOR_COUNT-1:0] r_pending, n_pending;
    ers_pkg::t_floor r_position, n_position;
    ers_pkg::t_floor r_target,   n_target;
    logic            r_last_up,  n_last_up;
    logic            r_mode;

    logic            r_kind;
    ers_pkg::t_floor r_call_floor;
    ers_pkg::t_pick  r_pick;

    ers_pkg::t_floor r_walk_floor, n_walk_floor;
    logic            r_walk_up,    n_walk_up;
    ers_pkg::t_pick  r_walk_k,     n_walk_k;
    logic            r_accepted,   n_accepted;
    logic            r_door,       n_door;

    ers_pkg::t_floor scan_floor;
    logic            scan_up;
    ers_pkg::t_floor hit_floor;
    logic            hit;
    logic            call_ok;
    ers_pkg::t_floor call_m1;
    ers_pkg::t_floor target_m1;
    ers_pkg::t_floor hit_m1;

    // Request bit of a floor; floors outside the building read as clear.
    function automatic logic pend_at(input logic [ers_pkg::FLOOR_COUNT-1:0] bits,
                                     input ers_pkg::t_floor f);
        ers_pkg::t_floor fm1;
        fm1 = f - ers_pkg::BOTTOM_FLOOR;
        pend_at = (f >= ers_pkg::BOTTOM_FLOOR) && (f <= ers_pkg::TOP_FLOOR) &&
                  bits[fm1[ers_pkg::IDX_W-1:0]];
    endfunction

    // One scan step: turn at the ends, then move one floor.
    always_comb begin
        if ((r_walk_floor <= ers_pkg::BOTTOM_FLOOR) && !r_walk_up) begin
            scan_up = 1'b1;
        end else if ((r_walk_floor >= ers_pkg::TOP_FLOOR) && r_walk_up) begin
            scan_up = 1'b0;
        end else begin
            scan_up = r_walk_up;
        end
        scan_floor = scan_up ? (r_walk_floor + ers_pkg::BOTTOM_FLOOR)
                             : (r_walk_floor - ers_pkg::BOTTOM_FLOOR);
    end

    assign hit_floor = (r_mode == ers_pkg::MODE_SCAN) ? scan_floor : r_walk_floor;
    assign hit = (r_mode == ers_pkg::MODE_SCAN) ? pend_at(r_pending, scan_floor)
               : (pend_at(r_pending, r_walk_floor) && (r_walk_k == '0));

    assign call_ok   = (r_call_floor >= ers_pkg::BOTTOM_FLOOR) &&
                       (r_call_floor <= ers_pkg::TOP_FLOOR) &&
                       !pend_at(r_pending, r_call_floor);
    assign call_m1   = r_call_floor - ers_pkg::BOTTOM_FLOOR;
    assign target_m1 = r_target - ers_pkg::BOTTOM_FLOOR;
    assign hit_m1    = hit_floor - ers_pkg::BOTTOM_FLOOR;

    assign o_stat.need_search = (r_kind == ers_pkg::KIND_TICK) &&
                                (r_target == ers_pkg::NO_FLOOR) && (|r_pending);
    assign o_stat.hit = hit;

    always_comb begin
        n_pending    = r_pending;
        n_position   = r_position;
        n_target     = r_target;
        n_last_up    = r_last_up;
        n_accepted   = r_accepted;
        n_door       = r_door;
        n_walk_floor = r_walk_floor;
        n_walk_up    = r_walk_up;
        n_walk_k     = r_walk_k;

        if (i_cmd.exec) begin
            n_accepted   = 1'b0;
            n_door       = 1'b0;
            n_walk_floor = (r_mode == ers_pkg::MODE_SCAN) ? r_position
                                                         : ers_pkg::BOTTOM_FLOOR;
            n_walk_up    = r_last_up;
            n_walk_k     = r_pick;
            if (r_kind == ers_pkg::KIND_CALL) begin
                if (call_ok) begin
                    n_pending[call_m1[ers_pkg::IDX_W-1:0]] = 1'b1;
                    n_accepted = 1'b1;
                end
            end else if (r_target == ers_pkg::NO_FLOOR) begin
                // selection, if any, runs in the walk
            end else if (r_position < r_target) begin
                n_position = r_position + ers_pkg::BOTTOM_FLOOR;
            end else if (r_position > r_target) begin
                n_position = r_position - ers_pkg::BOTTOM_FLOOR;
            end else begin
                n_door = 1'b1;
                n_pending[target_m1[ers_pkg::IDX_W-1:0]] = 1'b0;
                n_target = ers_pkg::NO_FLOOR;
            end
        end

        if (i_cmd.step) begin
            if (r_mode == ers_pkg::MODE_SCAN) begin
                n_walk_floor = scan_floor;
                n_walk_up    = scan_up;
            end else begin
                // Walk ascending with wraparound, counting pick down on each
                // pending floor: lands on entry (pick mod count).
                n_walk_floor = (r_walk_floor >= ers_pkg::TOP_FLOOR)
                             ? ers_pkg::BOTTOM_FLOOR
                             : (r_walk_floor + ers_pkg::BOTTOM_FLOOR);
                if (pend_at(r_pending, r_walk_floor) && (r_walk_k != '0)) begin
                    n_walk_k = r_walk_k - 3'd1;
                end
            end
            if (hit) begin
                n_target  = hit_floor;
                n_last_up = !(hit_floor < r_position);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending  <= '0;
            r_position <= ers_pkg::BOTTOM_FLOOR;
            r_target   <= ers_pkg::NO_FLOOR;
            r_last_up  <= 1'b1;
            r_mode     <= ers_pkg::MODE_NAIVE;
        end else begin
            r_pending  <= n_pending;
            r_position <= n_position;
            r_target   <= n_target;
            r_last_up  <= n_last_up;
            if (i_cfg_we) begin
                r_mode <= i_cfg_mode;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_walk_floor <= n_walk_floor;
        r_walk_up    <= n_walk_up;
        r_walk_k     <= n_walk_k;
        r_accepted   <= n_accepted;
        r_door       <= n_door;
        if (i_cmd.take) begin
            r_kind       <= i_kind;
            r_call_floor <= i_call_floor;
            r_pick       <= i_pick;
        end
        if (i_cmd.load) begin
            o_call_accepted <= r_accepted;
            o_cab_floor     <= r_position;
            o_goal_floor    <= r_target;
            o_door_open     <= r_door;
            o_heading_up    <= r_last_up;
        end
    end

    `ERS_ASSERT_NOW(a_target_pending, i_clk, i_rst_n, r_target != ers_pkg::NO_FLOOR, r_pending[target_m1[ers_pkg::IDX_W-1:0]] && (r_target <= ers_pkg::TOP_FLOOR))
    `ERS_ASSERT_NOW(a_position_range, i_clk, i_rst_n, 1'b1, (r_position >= ers_pkg::BOTTOM_FLOOR) && (r_position <= ers_pkg::TOP_FLOOR))
    `ERS_ASSERT_NEXT(a_hit_sets_target, i_clk, i_rst_n, i_cmd.step && hit, (r_target != ers_pkg::NO_FLOOR) && r_pending[target_m1[ers_pkg::IDX_W-1:0]] && ($past(hit_m1) == target_m1))

endmodule

`default_nettype wire

[design/ers_ctrl.sv]
// ---------------------------------------------------------------------------
// Elevator request scheduler controller
// Sequences accept, action, selection walk and result hand-off.
// ---------------------------------------------------------------------------
`default_nettype none

module ers_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output      logic            o_in_ready,
    output      logic            o_out_valid,
    input  wire logic            i_out_ready,
    output      ers_pkg::t_cmd   o_cmd,
    input  wire ers_pkg::t_stat  i_stat
);

`include "elevator_request_scheduler_assert.svh"

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_EXEC   = 2'd1;
    localparam logic [1:0] ST_SEARCH = 2'd2;
    localparam logic [1:0] ST_EMIT   = 2'd3;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_stat.need_search ? ST_SEARCH : ST_EMIT;
            end
            ST_SEARCH: begin
                o_cmd.step = 1'b1;
                if (i_stat.hit) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // hold until the result register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    `ERS_ASSERT_NEXT(a_exec_once, i_clk, i_rst_n, r_state == ST_EXEC, (r_state == ST_SEARCH) || (r_state == ST_EMIT))
    `ERS_ASSERT_NEXT(a_load_shows, i_clk, i_rst_n, o_cmd.load, r_out_valid && (r_state == ST_IDLE))
    `ERS_ASSERT_NOW(a_no_accept_busy, i_clk, i_rst_n, r_state != ST_IDLE, !o_in_ready && !o_cmd.take)

endmodule

`default_nettype wire

[test/tb_top.sv]
// ---------------------------------------------------------------------------
// Elevator request scheduler testbench
// Drives call and tick words in both selection modes, predicts every result
// word with a cycle-free model of the cab and checks each field in order.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ers_pkg::*;

    // One expected or observed result word.
    typedef struct packed {
        logic   accepted;
        t_floor cab;
        t_floor goal;
        logic   door;
        logic   up;
    } cab_result_t;

    // -----------------------------------------------------------------------
    // Cab tracker: keeps its own copy of the request bits, cab position,
    // target and heading, and queues the result word each input word implies.
    // -----------------------------------------------------------------------
    class cab_tracker;
        bit [FLOOR_COUNT:1] calls_waiting;
        int unsigned        call_total;
        int                 cab;
        int                 goal;
        bit                 up;
        logic               mode;
        cab_result_t        results_due[$];
        int                 errors;

        function new();
            calls_waiting = '0;
            call_total    = 0;
            cab           = 1;
            goal          = 0;
            up            = 1'b1;
            mode          = MODE_NAIVE;
            errors        = 0;
        endfunction

        function void set_mode(logic m);
            mode = m;
        endfunction

        // Naive choice: the (pick mod count)-th waiting floor, lowest first.
        function int pick_ascending(t_pick p);
            int unsigned k;
            k = p % call_total;
            for (int f = 1; f <= FLOOR_COUNT; f++) begin
                if (calls_waiting[f]) begin
                    if (k == 0)
                        return f;
                    k--;
                end
            end
            return 0;
        endfunction

        // Scan choice: walk from the cab in the current heading, bounce at
        // both ends, stop at the first waiting floor.
        function int scan_next();
            int f;
            bit dir;
            f   = cab;
            dir = up;
            for (int n = 0; n < 2 * FLOOR_COUNT; n++) begin
                if (f <= 1 && !dir)
                    dir = 1'b1;
                else if (f >= FLOOR_COUNT && dir)
                    dir = 1'b0;
                f = dir ? f + 1 : f - 1;
                if (f >= 1 && f <= FLOOR_COUNT && calls_waiting[f])
                    return f;
            end
            return 0;
        endfunction

        function void note_word(logic kind, t_floor fl, t_pick p);
            cab_result_t r;
            int          t;
            r = '0;
            if (kind == KIND_CALL) begin
                if (fl >= 1 && fl <= FLOOR_COUNT && !calls_waiting[fl]) begin
                    calls_waiting[fl] = 1'b1;
                    call_total++;
                    r.accepted = 1'b1;
                end
            end else if (goal == 0) begin
                if (call_total != 0) begin
                    t = (mode == MODE_SCAN) ? scan_next() : pick_ascending(p);
                    if (t != 0) begin
                        goal = t;
                        up   = (t < cab) ? 1'b0 : 1'b1;
                    end
                end
            end else if (cab < goal) begin
                cab++;
            end else if (cab > goal) begin
                cab--;
            end else begin
                r.door = 1'b1;
                if (calls_waiting[goal]) begin
                    calls_waiting[goal] = 1'b0;
                    if (call_total != 0)
                        call_total--;
                end
                goal = 0;
            end
            r.cab  = t_floor'(cab);
            r.goal = t_floor'(goal);
            r.up   = up;
            results_due.push_back(r);
        endfunction

        function void check_word(cab_result_t got);
            cab_result_t want;
            if (results_due.size() == 0) begin
                $display("%0t: result word with nothing expected", $time);
                errors++;
                return;
            end
            want = results_due.pop_front();
            if (got.accepted !== want.accepted) begin
                $display("%0t: call_accepted expected %0d actual %0d",
                         $time, want.accepted, got.accepted);
                errors++;
            end
            if (got.cab !== want.cab) begin
                $display("%0t: cab_floor expected %0d actual %0d",
                         $time, want.cab, got.cab);
                errors++;
            end
            if (got.goal !== want.goal) begin
                $display("%0t: goal_floor expected %0d actual %0d",
                         $time, want.goal, got.goal);
                errors++;
            end
            if (got.door !== want.door) begin
                $display("%0t: door_open expected %0d actual %0d",
                         $time, want.door, got.door);
                errors++;
            end
            if (got.up !== want.up) begin
                $display("%0t: heading_up expected %0d actual %0d",
                         $time, want.up, got.up);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    ers_item_if   item_ch ();
    ers_result_if res_ch ();
    ers_cfg_if    cfg_ch ();

    elevator_request_scheduler uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (res_ch),
        .i_cfg    (cfg_ch)
    );

    cab_tracker tracker;

    // Receiver controls: quiet keeps ready high, hold_cycles asks for one
    // long hold-off that the result side counts down on its own.
    bit quiet;
    int hold_cycles;

    // 20 ns clock.
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Gap before a word: mostly none or short, now and then long.
    function int gap_len();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Offer one word and hold it until taken. On return valid is still high
    // at the accept edge: the caller either offers the next word right away
    // or drops valid in this same step.
    task automatic send_word(logic kind, t_floor fl, t_pick p);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_ch.valid      <= 1'b1;
        item_ch.kind       <= kind;
        item_ch.call_floor <= fl;
        item_ch.pick       <= p;
        @(posedge i_clk);
        while (!item_ch.ready)
            @(posedge i_clk);
        tracker.note_word(kind, fl, p);
    endtask

    // Drop valid and wait until every expected result word has come back.
    task automatic drain();
        item_ch.valid <= 1'b0;
        while (tracker.results_due.size() != 0)
            @(posedge i_clk);
    endtask

    // Write select_mode; only called while the block is idle.
    task automatic write_mode(logic m);
        cfg_ch.valid       <= 1'b1;
        cfg_ch.select_mode <= m;
        @(posedge i_clk);
        while (!cfg_ch.ready)
            @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        tracker.set_mode(m);
    endtask

    // Random word: a phase-dependent share of ticks, calls mostly in range,
    // a few calls outside the building.
    task automatic send_random(int tick_pct);
        int     r;
        t_floor fl;
        r = $urandom_range(0, 99);
        if (r < tick_pct) begin
            send_word(KIND_TICK, t_floor'($urandom_range(0, 15)),
                      t_pick'($urandom_range(0, 7)));
        end else begin
            if ($urandom_range(0, 99) < 90)
                fl = t_floor'($urandom_range(1, FLOOR_COUNT));
            else if ($urandom_range(0, 1) == 0)
                fl = NO_FLOOR;
            else
                fl = t_floor'($urandom_range(FLOOR_COUNT + 1, 15));
            send_word(KIND_CALL, fl, t_pick'($urandom_range(0, 7)));
        end
    endtask

    // Result side: check each accepted word, then pick ready for the next
    // edge. Stalls are mostly short, sometimes long.
    initial begin : result_side
        cab_result_t got;
        int          stall;
        int          r;
        stall = 0;
        res_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (res_ch.valid && res_ch.ready) begin
                got.accepted = res_ch.call_accepted;
                got.cab      = res_ch.cab_floor;
                got.goal     = res_ch.goal_floor;
                got.door     = res_ch.door_open;
                got.up       = res_ch.heading_up;
                tracker.check_word(got);
            end
            if (hold_cycles > 0) begin
                stall       = hold_cycles;
                hold_cycles = 0;
            end
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                stall--;
            end else if (quiet) begin
                res_ch.ready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    res_ch.ready <= 1'b1;
                end else begin
                    res_ch.ready <= 1'b0;
                    stall = (r < 95) ? $urandom_range(0, 2) : $urandom_range(9, 39);
                end
            end
        end
    end

    // Stimulus and verdict.
    initial begin : stimulus
        int tick_pct;
        tracker     = new();
        quiet       = 1'b0;
        hold_cycles = 0;

        // Hold every input at a known value from time zero.
        i_rst_n            <= 1'b0;
        item_ch.valid      <= 1'b0;
        item_ch.kind       <= KIND_CALL;
        item_ch.call_floor <= NO_FLOOR;
        item_ch.pick       <= '0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.select_mode <= MODE_NAIVE;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, naive mode: idle tick, calls outside the building and at
        // both ends, a repeated call, selection with the widest pick, a call
        // to the floor already targeted, travel and service.
        write_mode(MODE_NAIVE);
        send_word(KIND_TICK, NO_FLOOR, t_pick'(0));
        send_word(KIND_CALL, NO_FLOOR, t_pick'(0));
        send_word(KIND_CALL, t_floor'(FLOOR_COUNT + 1), t_pick'(0));
        send_word(KIND_CALL, t_floor'(15), t_pick'(7));
        send_word(KIND_CALL, BOTTOM_FLOOR, t_pick'(0));
        send_word(KIND_CALL, TOP_FLOOR, t_pick'(0));
        send_word(KIND_CALL, TOP_FLOOR, t_pick'(0));
        send_word(KIND_CALL, t_floor'(4), t_pick'(0));
        send_word(KIND_TICK, t_floor'(15), t_pick'(7));
        send_word(KIND_CALL, t_floor'(4), t_pick'(0));
        repeat (4) send_word(KIND_TICK, NO_FLOOR, t_pick'(0));
        drain();

        // Directed, scan mode: sweep up to the top, then bounce back down.
        write_mode(MODE_SCAN);
        send_word(KIND_CALL, t_floor'(2), t_pick'(0));
        repeat (8) send_word(KIND_TICK, NO_FLOOR, t_pick'(0));
        drain();

        // Random phases, alternating modes with a different tick share each.
        for (int phase = 0; phase < 4; phase++) begin
            write_mode((phase % 2 == 1) ? MODE_SCAN : MODE_NAIVE);
            tick_pct = $urandom_range(40, 65);
            for (int n = 0; n < 357; n++) begin
                // Run a stretch with no idling on either side.
                quiet = (phase == 3 && n < 120);
                // Stall the receiver long enough for the block to fill and
                // push back on the sender.
                if (phase == 1 && n == 100)
                    hold_cycles = 400;
                // Pause the sender until the block has emptied, then go on.
                if (phase == 2 && n == 200)
                    drain();
                send_random(tick_pct);
            end
            quiet = 1'b0;
            drain();
        end

        // Let a late stray word show up before the verdict.
        repeat (100) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.results_due.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Guard against a hang.
    initial begin : watchdog
        #15ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire
